@@ sv/ovt_pkg.sv @@
// Package for the object version table: codes, sizes and the search transaction type.
package ovt_pkg;

    localparam int OVT_TABLE_ENTRIES = 64;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int VER_W    = 64;
    localparam int TX_W     = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_GET_VERSION = 3'd0;
    localparam logic [OP_W-1:0] OP_START_TX    = 3'd1;
    localparam logic [OP_W-1:0] OP_LOCK        = 3'd2;
    localparam logic [OP_W-1:0] OP_UNLOCK      = 3'd3;
    localparam logic [OP_W-1:0] OP_BUMP        = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADCMD = 2'd3;

    // Search transaction walking the row of table cells.
    typedef struct packed {
        logic             vld;
        logic             bump;
        logic [KEY_W-1:0] key;
        logic             hit;
        logic [VER_W-1:0] ver;
    } ovt_tok_t;

endpackage

@@ sv/object_version_table.sv @@
// Top level of the object version table: request decode, cell row and result register.
//
// Usage:
//   Requests enter on the s_ channel (s_operation, s_object_offset) with a
//   valid/ready handshake; one result per request leaves on the m_ channel
//   (m_value, m_status), also valid/ready, in request order.
//   Start transaction, lock, unlock and invalid operations are decoded at
//   once: the result is in the output register in the cycle after the
//   transaction is accepted.
//   Get version and bump version walk a row of TABLE_ENTRIES cells, one cell
//   per cycle, and their result then passes to the output register. One
//   such request is in the row at a time, and no other request is accepted
//   until its result reaches the output register; the decoded ones are taken
//   one per cycle while the receiver does not stall.
//   Reset (aresetn low, synchronous) empties the table, clears the
//   transaction counter and the lock flag, and drops any result in flight.
//   When the receiver stalls, the finished result holds in the output
//   register (a result leaving the cell row parks in a holding register) and
//   s_ready drops until the output register can take a new result.
module object_version_table #(
    parameter int TABLE_ENTRIES = ovt_pkg::OVT_TABLE_ENTRIES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ovt_pkg::OP_W-1:0]      s_operation,
    input  logic [ovt_pkg::KEY_W-1:0]     s_object_offset,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ovt_pkg::VER_W-1:0]     m_value,
    output logic [ovt_pkg::STATUS_W-1:0]  m_status
);
    import ovt_pkg::*;

    // Links between cells; link 0 feeds the first cell, the last link leaves the row.
    ovt_tok_t link [0:TABLE_ENTRIES];

    logic                busy_reg;
    logic                busy_next;
    logic                lock_reg;
    logic                lock_next;
    logic [TX_W-1:0]     tx_reg;
    logic [TX_W-1:0]     tx_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [VER_W-1:0]    m_value_reg;
    logic [VER_W-1:0]    m_value_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [STATUS_W-1:0] m_status_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    logic [VER_W-1:0]    pend_value_reg;
    logic [VER_W-1:0]    pend_value_next;
    logic [STATUS_W-1:0] pend_status_reg;
    logic [STATUS_W-1:0] pend_status_next;

    logic                out_free;
    logic                accept;
    logic                is_search;
    logic [VER_W-1:0]    row_value;
    logic [STATUS_W-1:0] row_status;

    // The output register can load when empty or being emptied this cycle.
    // Hold ready low while reset is applied so no transaction is taken and dropped.
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = aresetn && !busy_reg && out_free;
    assign accept    = s_valid && s_ready;
    assign is_search = (s_operation == OP_GET_VERSION) || (s_operation == OP_BUMP);

    // Launch a search transaction into the first cell.
    assign link[0] = '{
        vld:  accept && is_search,
        bump: (s_operation == OP_BUMP),
        key:  s_object_offset,
        hit:  1'b0,
        ver:  '0
    };

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        ovt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (link[i]),
            .tok_o   (link[i+1])
        );
    end

    // Result of a transaction leaving the row: a miss on get means the table is full.
    always_comb begin
        row_value  = '0;
        row_status = ST_OK;
        if (!link[TABLE_ENTRIES].bump) begin
            if (link[TABLE_ENTRIES].hit) begin
                row_value = link[TABLE_ENTRIES].ver;
            end else begin
                row_status = ST_FULL;
            end
        end
    end

    always_comb begin
        busy_next        = busy_reg;
        lock_next        = lock_reg;
        tx_next          = tx_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_value_next     = m_value_reg;
        m_status_next    = m_status_reg;
        pend_valid_next  = pend_valid_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;

        if (accept) begin
            if (is_search) begin
                // hold new requests until the row result reaches the output
                busy_next = 1'b1;
            end else begin
                m_valid_next = 1'b1;
                m_value_next = '0;
                unique case (s_operation)
                    OP_START_TX: begin
                        tx_next       = tx_reg + TX_W'(1);
                        m_value_next  = VER_W'(tx_next);
                        m_status_next = ST_OK;
                    end
                    OP_LOCK: begin
                        m_status_next = lock_reg ? ST_BUSY : ST_OK;
                        lock_next     = 1'b1;
                    end
                    OP_UNLOCK: begin
                        m_status_next = ST_OK;
                        lock_next     = 1'b0;
                    end
                    default: begin
                        m_status_next = ST_BADCMD;
                    end
                endcase
            end
        end

        if (link[TABLE_ENTRIES].vld) begin
            if (out_free) begin
                m_valid_next  = 1'b1;
                m_value_next  = row_value;
                m_status_next = row_status;
                busy_next     = 1'b0;
            end else begin
                // receiver stalled: park the result
                pend_valid_next  = 1'b1;
                pend_value_next  = row_value;
                pend_status_next = row_status;
            end
        end else if (pend_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_value_next    = pend_value_reg;
            m_status_next   = pend_status_reg;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            lock_reg       <= 1'b0;
            tx_reg         <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            lock_reg       <= lock_next;
            tx_reg         <= tx_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg     <= m_value_next;
        m_status_reg    <= m_status_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

endmodule

@@ sv/ovt_cell.sv @@
// One table cell: holds a key/version pair and passes the search transaction on.
module ovt_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  ovt_pkg::ovt_tok_t tok_i,
    output ovt_pkg::ovt_tok_t tok_o
);
    import ovt_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [VER_W-1:0] ver_reg;
    logic [VER_W-1:0] ver_next;
    ovt_tok_t         tok_reg;
    ovt_tok_t         tok_next;
    logic             match;
    logic             insert;

    assign match  = tok_i.vld && valid_reg && (key_reg == tok_i.key);
    assign insert = tok_i.vld && !valid_reg && !tok_i.hit && !tok_i.bump;

    always_comb begin
        tok_next   = tok_i;
        valid_next = valid_reg;
        key_next   = key_reg;
        ver_next   = ver_reg;
        if (match) begin
            tok_next.hit = 1'b1;
            if (tok_i.bump) begin
                ver_next = ver_reg + VER_W'(1);
            end else begin
                tok_next.ver = ver_reg;
            end
        end else if (insert) begin
            // first empty cell reached: the key is absent, claim this cell
            tok_next.hit = 1'b1;
            tok_next.ver = VER_W'(1);
            valid_next   = 1'b1;
            key_next     = tok_i.key;
            ver_next     = VER_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        ver_reg <= ver_next;
    end

    assign tok_o = tok_reg;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the object version table, with scoreboard and request drivers.
`timescale 1ns / 100ps

import ovt_pkg::*;

// Scoreboard: mirrors the table, the start-tx counter and the lock flag.
// It also holds the queue of results still owed by the block.
class version_scoreboard;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [KEY_W-1:0]    key;
        logic [VER_W-1:0]    value;
        logic [STATUS_W-1:0] status;
    } owed_result_t;

    logic [KEY_W-1:0] stored_keys[$];
    logic [VER_W-1:0] stored_versions[$];
    logic [TX_W-1:0]  tx_count;
    logic             lock_flag;
    owed_result_t     owed_results[$];

    int failures;
    int reported;
    int accepted;
    int hits;
    int inserts;
    int full_misses;
    int tx_starts;
    int bumps_applied;
    int bumps_ignored;
    int busy_locks;
    int bad_commands;

    function new();
        tx_count      = '0;
        lock_flag     = 1'b0;
        failures      = 0;
        reported      = 0;
        accepted      = 0;
        hits          = 0;
        inserts       = 0;
        full_misses   = 0;
        tx_starts     = 0;
        bumps_applied = 0;
        bumps_ignored = 0;
        busy_locks    = 0;
        bad_commands  = 0;
    endfunction

    function int find_entry(logic [KEY_W-1:0] key);
        foreach (stored_keys[i]) begin
            if (stored_keys[i] == key) return i;
        end
        return -1;
    endfunction

    function void note_failure(string what);
        failures++;
        if (reported < 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
            reported++;
        end
    endfunction

    // Work out the result of an accepted request and update the mirrored state.
    function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        owed_result_t due;
        int           slot;
        due.op     = op;
        due.key    = key;
        due.value  = '0;
        due.status = ST_OK;
        case (op)
            OP_GET_VERSION: begin
                slot = find_entry(key);
                if (slot >= 0) begin
                    due.value = stored_versions[slot];
                    hits++;
                end else if (stored_keys.size() < OVT_TABLE_ENTRIES) begin
                    stored_keys.push_back(key);
                    stored_versions.push_back(VER_W'(1));
                    due.value = VER_W'(1);
                    inserts++;
                end else begin
                    due.status = ST_FULL;
                    full_misses++;
                end
            end
            OP_START_TX: begin
                tx_count  = tx_count + 1'b1;
                due.value = VER_W'(tx_count);
                tx_starts++;
            end
            OP_LOCK: begin
                if (lock_flag) begin
                    due.status = ST_BUSY;
                    busy_locks++;
                end else begin
                    lock_flag = 1'b1;
                end
            end
            OP_UNLOCK: begin
                lock_flag = 1'b0;
            end
            OP_BUMP: begin
                slot = find_entry(key);
                if (slot >= 0) begin
                    stored_versions[slot] = stored_versions[slot] + 1'b1;
                    bumps_applied++;
                end else begin
                    bumps_ignored++;
                end
            end
            default: begin
                due.status = ST_BADCMD;
                bad_commands++;
            end
        endcase
        owed_results.push_back(due);
        accepted++;
    endfunction

    // Compare one result with the oldest one owed.
    function void check_result(logic [VER_W-1:0] value, logic [STATUS_W-1:0] status);
        owed_result_t due;
        if (owed_results.size() == 0) begin
            note_failure($sformatf("result with nothing outstanding: value %h status %0d",
                                   value, status));
            return;
        end
        due = owed_results.pop_front();
        if (value !== due.value || status !== due.status) begin
            note_failure($sformatf(
                "op %0d key %h: expected value %h status %0d, got value %h status %0d",
                due.op, due.key, due.value, due.status, value, status));
        end
    endfunction

endclass

module testbench;

    // Unused operation codes, all of which must come back as bad commands.
    localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    // Stop the stimulus once this many requests have been accepted.
    localparam int ITEM_TARGET = 1300;
    // Time to watch for stray results after draining, scaled by the table length.
    localparam int DRAIN_CYCLES = 2 * OVT_TABLE_ENTRIES + 8;
    // Watchdog bound: it allows for a table walk, the longest gap and the longest
    // stall on every request, several times over.
    localparam int CYCLE_LIMIT = 600000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation = '0;
    logic [KEY_W-1:0]    s_object_offset = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [VER_W-1:0]    m_value;
    logic [STATUS_W-1:0] m_status;

    version_scoreboard sb;
    bit                steady = 1'b0;  // set: no gaps and no stalls on either side
    int                cycle_count = 0;

    object_version_table #(
        .TABLE_ENTRIES(OVT_TABLE_ENTRIES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_object_offset(s_object_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_status       (m_status)
    );

    always #1 aclk = ~aclk;

    // Idle length shared by both sides: mostly none or short, now and then long.
    function automatic int idle_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Choose a key: mostly one already stored, sometimes a fresh one, and
    // sometimes a stored key with a single bit flipped to probe the compare.
    function automatic logic [KEY_W-1:0] pick_key();
        int               n;
        int               roll;
        logic [KEY_W-1:0] key;
        n    = sb.stored_keys.size();
        roll = $urandom_range(0, 99);
        if (n == 0 || roll < 25) return $urandom;
        key = sb.stored_keys[$urandom_range(0, n - 1)];
        if (roll < 40) key = key ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
        return key;
    endfunction

    // Present one request at the falling edge and hold it until the
    // transaction completes; then either drop valid for a gap or leave it
    // high so the next request follows straight on.
    task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        int gap;
        @(negedge aclk);
        s_valid         = 1'b1;
        s_operation     = op;
        s_object_offset = key;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, key);
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid         = 1'b0;
            s_operation     = OP_W'($urandom);
            s_object_offset = $urandom;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // A well-formed client transaction: start, take the lock, read some
    // versions, bump some, read again, release. Lock and release are
    // skipped now and then so busy locks and idle releases turn up too.
    task automatic run_client_transaction();
        send_request(OP_START_TX, $urandom);
        if ($urandom_range(0, 3) != 0) send_request(OP_LOCK, $urandom);
        repeat ($urandom_range(1, 4)) send_request(OP_GET_VERSION, pick_key());
        repeat ($urandom_range(0, 3)) send_request(OP_BUMP, pick_key());
        if ($urandom_range(0, 1) != 0) send_request(OP_GET_VERSION, pick_key());
        if ($urandom_range(0, 4) != 0) send_request(OP_UNLOCK, $urandom);
    endtask

    // Result side: check at the rising edge, decide ready at the falling edge.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_value, m_status);
            @(negedge aclk);
            if (stall_left > 0 && !steady) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready    = 1'b1;
                stall_left = idle_gap();
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        sb = new();

        // Hold reset, then release it at a falling edge.
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: lock flag corners, bump of an absent key, insert then hit,
        // extreme keys, start-tx and every unused operation code.
        send_request(OP_UNLOCK,      32'h0000_0000);
        send_request(OP_LOCK,        32'hFFFF_FFFF);
        send_request(OP_LOCK,        32'h0000_0000);
        send_request(OP_UNLOCK,      32'hFFFF_FFFF);
        send_request(OP_BUMP,        32'h0000_0000);
        send_request(OP_GET_VERSION, 32'h0000_0000);
        send_request(OP_GET_VERSION, 32'h0000_0000);
        send_request(OP_BUMP,        32'h0000_0000);
        send_request(OP_GET_VERSION, 32'h0000_0000);
        send_request(OP_GET_VERSION, 32'hFFFF_FFFF);
        send_request(OP_GET_VERSION, 32'h8000_0000);
        send_request(OP_GET_VERSION, 32'h0000_0001);
        send_request(OP_BUMP,        32'hFFFF_FFFF);
        send_request(OP_GET_VERSION, 32'hFFFF_FFFF);
        send_request(OP_BUMP,        32'hFFFF_FFFE);
        send_request(OP_START_TX,    32'h0000_0000);
        send_request(OP_START_TX,    32'hFFFF_FFFF);
        send_request(OP_UNUSED_5,    32'h0000_0000);
        send_request(OP_UNUSED_6,    32'hFFFF_FFFF);
        send_request(OP_UNUSED_7,    32'h5A5A_A5A5);
        send_request(OP_GET_VERSION, 32'h7FFF_FFFF);

        // Random: mostly client transactions, some noise. The table fills up
        // part-way through, after which misses come back as table full.
        while (sb.accepted < ITEM_TARGET) begin
            if ($urandom_range(0, 6) == 0) steady = ~steady;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 5))
                    send_request(OP_W'($urandom_range(0, 7)), $urandom);
            end else begin
                run_client_transaction();
            end
        end

        // Drop valid, let every owed result arrive, then watch for strays.
        @(negedge aclk);
        s_valid = 1'b0;
        steady  = 1'b0;
        while (sb.owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests: %0d version hits, %0d inserts (%0d of %0d slots used),",
                 sb.accepted, sb.hits, sb.inserts, sb.stored_keys.size(), OVT_TABLE_ENTRIES);
        $display("%0d full misses, %0d start-tx, bumps applied %0d, ignored %0d;",
                 sb.full_misses, sb.tx_starts, sb.bumps_applied, sb.bumps_ignored);
        $display("busy locks %0d; bad commands %0d; %0d mismatches",
                 sb.busy_locks, sb.bad_commands, sb.failures);
        if (sb.failures == 0 && sb.owed_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ovt_pkg.sv
sv/ovt_cell.sv
sv/object_version_table.sv
tb/sv/testbench.sv
